@@ design/servo_alarm_latch_with_clear_pulse_assert.svh @@
// Assertion macros shared by the servo alarm latch modules.
`ifndef SERVO_ALARM_LATCH_WITH_CLEAR_PULSE_ASSERT_SVH
`define SERVO_ALARM_LATCH_WITH_CLEAR_PULSE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SAL_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("servo alarm latch: check failed");

// Next-cycle implication, checked out of reset.
`define SAL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("servo alarm latch: check failed");

`endif

@@ design/sal_pkg.sv @@
// Types and constants of the servo alarm latch.
package sal_pkg;

    // Latch state, also the alarm_state output code
    typedef enum logic [1:0] {
        ST_CLEAR    = 2'd0,
        ST_ALARM    = 2'd1,
        ST_CLEARING = 2'd2
    } alarm_state_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd2;

    localparam int unsigned CFG_W  = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CNT_W  = 32;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd10;
    localparam logic [CFG_W-1:0] PULSE_RST    = 16'd100;
    localparam logic [CFG_W-1:0] SETTLE_RST   = 16'd60;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] pulse_ms;
        logic [CFG_W-1:0] settle_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              alarm_level;
        logic              clear_request;
        logic              take_trip;
    } in_item_t;

    typedef struct packed {
        alarm_state_t     alarm_state;
        logic             enable_pulse;
        logic             trip_taken;
        logic             clear_failed;
        logic [CNT_W-1:0] trip_total;
        logic             filtered_level;
    } out_item_t;

endpackage

@@ design/sal_cfg_regs.sv @@
// Configuration registers of the servo alarm latch.
module sal_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sal_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sal_pkg::CFG_W-1:0]         cfg_data,
    output sal_pkg::cfg_t                     cfg
);

    sal_pkg::cfg_t cfg_reg;
    sal_pkg::cfg_t cfg_next;

    // Decode the write; unknown index is dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                sal_pkg::CFG_DEBOUNCE: cfg_next.debounce_ms = cfg_data;
                sal_pkg::CFG_PULSE:    cfg_next.pulse_ms    = cfg_data;
                sal_pkg::CFG_SETTLE:   cfg_next.settle_ms   = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms <= sal_pkg::DEBOUNCE_RST;
            cfg_reg.pulse_ms    <= sal_pkg::PULSE_RST;
            cfg_reg.settle_ms   <= sal_pkg::SETTLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/sal_step.sv @@
// Debounce filter, alarm latch state machine and trip bookkeeping.
`include "servo_alarm_latch_with_clear_pulse_assert.svh"

module sal_step
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  sal_pkg::in_item_t    item,
    input  sal_pkg::cfg_t        cfg,
    output sal_pkg::out_item_t   result
);

    sal_pkg::alarm_state_t              state_reg, state_next;
    logic                               raw_reg, raw_next;
    logic                               deb_reg, deb_next;
    logic [sal_pkg::TIME_W-1:0]         change_time_reg, change_time_next;
    logic                               enable_reg, enable_next;
    logic [sal_pkg::TIME_W-1:0]         pulse_start_reg, pulse_start_next;
    logic [sal_pkg::TIME_W-1:0]         settle_start_reg, settle_start_next;
    logic                               settling_reg, settling_next;
    logic                               clr_pend_reg, clr_pend_next;
    logic                               trip_pend_reg, trip_pend_next;
    logic                               failed_reg, failed_next;
    logic [sal_pkg::CNT_W-1:0]          trip_cnt_reg, trip_cnt_next;
    logic                               taken;

    // Elapsed times, modulo 2^32
    logic [sal_pkg::TIME_W-1:0] since_change;
    logic [sal_pkg::TIME_W-1:0] since_pulse;
    logic [sal_pkg::TIME_W-1:0] since_settle;
    logic                       debounce_done;
    logic                       pulse_done;
    logic                       settle_done;

    assign since_change  = item.now_ms - change_time_reg;
    assign since_pulse   = item.now_ms - pulse_start_reg;
    assign since_settle  = item.now_ms - settle_start_reg;
    assign debounce_done = since_change >= {{(sal_pkg::TIME_W-sal_pkg::CFG_W){1'b0}},
                                            cfg.debounce_ms};
    assign pulse_done    = since_pulse  >= {{(sal_pkg::TIME_W-sal_pkg::CFG_W){1'b0}},
                                            cfg.pulse_ms};
    assign settle_done   = since_settle >= {{(sal_pkg::TIME_W-sal_pkg::CFG_W){1'b0}},
                                            cfg.settle_ms};

    // Next state of the filter and the latch for the item in the input register
    always_comb
    begin
        state_next        = state_reg;
        raw_next          = raw_reg;
        deb_next          = deb_reg;
        change_time_next  = change_time_reg;
        enable_next       = enable_reg;
        pulse_start_next  = pulse_start_reg;
        settle_start_next = settle_start_reg;
        settling_next     = settling_reg;
        clr_pend_next     = clr_pend_reg | item.clear_request;
        trip_pend_next    = trip_pend_reg;
        failed_next       = failed_reg;
        trip_cnt_next     = trip_cnt_reg;
        taken             = 1'b0;

        // filter holds still while clearing
        if (state_reg != sal_pkg::ST_CLEARING)
        begin
            if (item.alarm_level != raw_reg)
            begin
                raw_next         = item.alarm_level;
                change_time_next = item.now_ms;
            end
            else if ((raw_reg != deb_reg) && debounce_done)
            begin
                deb_next = raw_reg;
            end
        end

        case (state_reg)
            sal_pkg::ST_ALARM:
            begin
                if (clr_pend_next)
                begin
                    clr_pend_next    = 1'b0;
                    failed_next      = 1'b0;
                    state_next       = sal_pkg::ST_CLEARING;
                    enable_next      = 1'b1;
                    pulse_start_next = item.now_ms;
                    settling_next    = 1'b0;
                end
            end
            sal_pkg::ST_CLEARING:
            begin
                clr_pend_next = 1'b0;
                if (!settling_reg)
                begin
                    if (pulse_done)
                    begin
                        enable_next       = 1'b0;
                        settling_next     = 1'b1;
                        settle_start_next = item.now_ms;
                    end
                end
                else if (settle_done)
                begin
                    // reseed the filter from this sample and judge the clear
                    raw_next         = item.alarm_level;
                    deb_next         = item.alarm_level;
                    change_time_next = item.now_ms;
                    settling_next    = 1'b0;
                    state_next       = item.alarm_level ? sal_pkg::ST_ALARM
                                                        : sal_pkg::ST_CLEAR;
                    failed_next      = item.alarm_level;
                end
            end
            default:
            begin
                // clear, and the unused code treated as clear
                state_next = sal_pkg::ST_CLEAR;
                if (deb_next)
                begin
                    state_next     = sal_pkg::ST_ALARM;
                    trip_pend_next = 1'b1;
                    trip_cnt_next  = trip_cnt_reg + {{(sal_pkg::CNT_W-1){1'b0}}, 1'b1};
                end
            end
        endcase

        if (state_next != sal_pkg::ST_CLEARING)
        begin
            enable_next = 1'b0;
        end

        // trip acknowledge reads then clears the pending flag
        if (item.take_trip)
        begin
            taken          = trip_pend_next;
            trip_pend_next = 1'b0;
        end
    end

    // Result item for the item in the input register
    always_comb
    begin
        result.alarm_state    = state_next;
        result.enable_pulse   = enable_next;
        result.trip_taken     = taken;
        result.clear_failed   = failed_next;
        result.trip_total     = trip_cnt_next;
        result.filtered_level = deb_next;
    end

    // State registers, updated when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sal_pkg::ST_CLEAR;
            raw_reg          <= 1'b0;
            deb_reg          <= 1'b0;
            change_time_reg  <= '0;
            enable_reg       <= 1'b0;
            pulse_start_reg  <= '0;
            settle_start_reg <= '0;
            settling_reg     <= 1'b0;
            clr_pend_reg     <= 1'b0;
            trip_pend_reg    <= 1'b0;
            failed_reg       <= 1'b0;
            trip_cnt_reg     <= '0;
        end
        else if (fire)
        begin
            state_reg        <= state_next;
            raw_reg          <= raw_next;
            deb_reg          <= deb_next;
            change_time_reg  <= change_time_next;
            enable_reg       <= enable_next;
            pulse_start_reg  <= pulse_start_next;
            settle_start_reg <= settle_start_next;
            settling_reg     <= settling_next;
            clr_pend_reg     <= clr_pend_next;
            trip_pend_reg    <= trip_pend_next;
            failed_reg       <= failed_next;
            trip_cnt_reg     <= trip_cnt_next;
        end
    end

    // Checks
    `SAL_ASSERT_IMPL(a_enable_only_clearing, clk, rst_n, enable_reg, state_reg == sal_pkg::ST_CLEARING)
    `SAL_ASSERT_NEXT(a_state_holds_idle, clk, rst_n, !fire, $stable(state_reg) && $stable(trip_cnt_reg))
    `SAL_ASSERT_IMPL(a_trip_count_step, clk, rst_n, !$stable(trip_cnt_reg), trip_cnt_reg == $past(trip_cnt_reg) + 32'd1)

endmodule

@@ design/servo_alarm_latch_with_clear_pulse.sv @@
// Servo alarm latch: one sample in, one result out, every cycle while out_ready
// stays high. Each accepted item lands in an input register, where the debounce
// filter and latch logic evaluate it against the held state; the result register
// is loaded with that outcome when the item advances out of the input register.
// Throughput is one item per cycle as long as out_ready stays high; the input
// register and the result register form a two-stage pipe, and the state update of
// one item is done in the same cycle that moves it to the result register, so the
// next item sees it at once.
// Configuration writes (debounce, pulse and settle times in ms) take effect on
// the following cycle and are meant to be made while no item is in flight.
`include "servo_alarm_latch_with_clear_pulse_assert.svh"

module servo_alarm_latch_with_clear_pulse
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [sal_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sal_pkg::CFG_W-1:0]         cfg_data,
    // sample items
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sal_pkg::TIME_W-1:0]        now_ms,
    input  logic                              alarm_level,
    input  logic                              clear_request,
    input  logic                              take_trip,
    // result items
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        alarm_state,
    output logic                              enable_pulse,
    output logic                              trip_taken,
    output logic                              clear_failed,
    output logic [sal_pkg::CNT_W-1:0]         trip_total,
    output logic                              filtered_level
);

    sal_pkg::cfg_t      cfg;
    sal_pkg::in_item_t  item_reg;
    logic               in_valid_reg;
    sal_pkg::out_item_t result;
    sal_pkg::out_item_t out_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               in_fire;

    // Pipe control
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    sal_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sal_step u_step
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.now_ms        <= now_ms;
            item_reg.alarm_level   <= alarm_level;
            item_reg.clear_request <= clear_request;
            item_reg.take_trip     <= take_trip;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign alarm_state    = out_reg.alarm_state;
    assign enable_pulse   = out_reg.enable_pulse;
    assign trip_taken     = out_reg.trip_taken;
    assign clear_failed   = out_reg.clear_failed;
    assign trip_total     = out_reg.trip_total;
    assign filtered_level = out_reg.filtered_level;

    // Checks
    `SAL_ASSERT_NEXT(a_item_held_stalled, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    `SAL_ASSERT_IMPL(a_no_overwrite, clk, rst_n, advance, !out_valid_reg || out_ready)
    `SAL_ASSERT_IMPL(a_enable_out_clearing, clk, rst_n, out_valid_reg && enable_pulse, alarm_state == sal_pkg::ST_CLEARING)

endmodule
